/* rtl/particle_motion_integrator_core_macros.svh */
// Assertion macros for the particle motion integrator.
// Included by files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef PARTICLE_MOTION_INTEGRATOR_CORE_MACROS_SVH
`define PARTICLE_MOTION_INTEGRATOR_CORE_MACROS_SVH

// same-cycle implication
`define PMI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PMI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pmi_pkg.sv */
// Shared types, constants and helper functions for the particle motion integrator.
// No dependencies; used by the core and the testbench.
`timescale 1ns / 1ps

package pmi_pkg;

	localparam int unsigned MAX_PARTICLES_DEF = 1024;
	localparam int unsigned FRAC_BITS_DEF     = 16;

	localparam int unsigned IDX_W  = 10;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned MASS_W = 31;
	localparam int unsigned DT_W   = 31;
	localparam int unsigned ADDR_W = 5;

	// register map, word index = paddr[4:2]
	typedef enum logic [2:0] {
		REG_MODE      = 3'd0,
		REG_TIME_STEP = 3'd1,
		REG_GRAVITY_X = 3'd2,
		REG_GRAVITY_Y = 3'd3,
		REG_GRAVITY_Z = 3'd4
	} reg_idx_t;

	localparam logic [DT_W-1:0]          TIME_STEP_RST = 31'd65;
	localparam logic signed [DATA_W-1:0] GRAV_X_RST    = 32'sd0;
	localparam logic signed [DATA_W-1:0] GRAV_Y_RST    = 32'sd0;
	localparam logic signed [DATA_W-1:0] GRAV_Z_RST    = -32'sd642253;

	typedef logic [2:0][DATA_W-1:0] vec3_t;

	// per-lane sign and nonzero flags plus a zero-mass flag, carried alongside the quotient
	typedef struct packed {
		logic [2:0] neg;
		logic [2:0] nz;
		logic       mzero;
	} div_flags_t;

	function automatic logic signed [63:0] sx64(input logic [DATA_W-1:0] v);
		return {{(64-DATA_W){v[DATA_W-1]}}, v};
	endfunction

	function automatic logic signed [DATA_W:0] sx33(input logic [DATA_W-1:0] v);
		return {v[DATA_W-1], v};
	endfunction

	// clamp to the signed 32 bit range
	function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] x);
		logic [DATA_W-1:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (x < -64'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = x[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

/* rtl/particle_motion_integrator_core.sv */
// Particle motion integrator top level: divider pipeline, acceleration store, update stages.
// Depends on pmi_pkg, pmi_ram and particle_motion_integrator_core_macros.svh.
`timescale 1ns / 1ps
`include "particle_motion_integrator_core_macros.svh"

// Usage
//  Input channel (in_valid / in_stall): one particle per request - index, position,
//  velocity, contact force and mass. Output channel (out_valid / out_stall): one request
//  per particle with the echoed index, new position, velocity and acceleration.
//  APB-style port sets mode, time step and gravity; write only while the block is idle.
//  Throughput: one particle per cycle unless a stalled output holds the pipeline.
//  Force/mass quotient: restoring divider of 32+FRAC_BITS stages, one quotient bit per
//  stage, three lanes; then stages 1 to 4 and the output register lead to out_valid.
//  The previous acceleration of each particle sits in one RAM (x, y, z side by side),
//  read as the quotient leaves the divider and written back from stage 1; a
//  same-slot pair in those two stages is forwarded.
//  Reset: registers return to their defaults, then a clearing pass zeroes the RAM,
//  one entry a cycle over all MAX_PARTICLES entries; in_stall stays high meanwhile.
//  Stall: a waiting result sits in the output register and the pipeline keeps
//  taking particles until its last stage is occupied; then the whole pipeline holds.

module particle_motion_integrator_core #(
	parameter int unsigned MAX_PARTICLES = pmi_pkg::MAX_PARTICLES_DEF,
	parameter int unsigned FRAC_BITS     = pmi_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pmi_pkg::ADDR_W-1:0]         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// particle requests
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [pmi_pkg::IDX_W-1:0]          particle_index,
	input  logic signed [pmi_pkg::DATA_W-1:0]  pos_x,
	input  logic signed [pmi_pkg::DATA_W-1:0]  pos_y,
	input  logic signed [pmi_pkg::DATA_W-1:0]  pos_z,
	input  logic signed [pmi_pkg::DATA_W-1:0]  vel_x,
	input  logic signed [pmi_pkg::DATA_W-1:0]  vel_y,
	input  logic signed [pmi_pkg::DATA_W-1:0]  vel_z,
	input  logic signed [pmi_pkg::DATA_W-1:0]  force_x,
	input  logic signed [pmi_pkg::DATA_W-1:0]  force_y,
	input  logic signed [pmi_pkg::DATA_W-1:0]  force_z,
	input  logic [pmi_pkg::MASS_W-1:0]         mass,
	// results
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pmi_pkg::IDX_W-1:0]          out_index,
	output logic signed [pmi_pkg::DATA_W-1:0]  new_pos_x,
	output logic signed [pmi_pkg::DATA_W-1:0]  new_pos_y,
	output logic signed [pmi_pkg::DATA_W-1:0]  new_pos_z,
	output logic signed [pmi_pkg::DATA_W-1:0]  new_vel_x,
	output logic signed [pmi_pkg::DATA_W-1:0]  new_vel_y,
	output logic signed [pmi_pkg::DATA_W-1:0]  new_vel_z,
	output logic signed [pmi_pkg::DATA_W-1:0]  new_acc_x,
	output logic signed [pmi_pkg::DATA_W-1:0]  new_acc_y,
	output logic signed [pmi_pkg::DATA_W-1:0]  new_acc_z
);

	import pmi_pkg::*;

	localparam int unsigned SW     = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int unsigned DW     = DATA_W + FRAC_BITS;
	localparam int unsigned ND     = DW;
	localparam int unsigned MEM_W  = 3 * DATA_W;
	localparam bit          FULL_IDX = (MAX_PARTICLES >= (1 << IDX_W));
	// slot = index mod MAX_PARTICLES through a reciprocal multiply
	localparam int unsigned MOD_SH    = 24;
	localparam int unsigned MOD_RECIP = FULL_IDX ? 1 :
		((1 << MOD_SH) + MAX_PARTICLES - 1) / MAX_PARTICLES;
	localparam logic [IDX_W:0] MOD_M  = (IDX_W+1)'(MAX_PARTICLES);
	localparam int unsigned MP_W      = IDX_W + MOD_SH + 1;

	// ------------------------------------------------------------------
	// configuration registers
	logic                    mode_q;
	logic [DT_W-1:0]         time_step_q;
	vec3_t                   grav_q;
	logic                    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			time_step_q <= TIME_STEP_RST;
			grav_q[0]   <= GRAV_X_RST;
			grav_q[1]   <= GRAV_Y_RST;
			grav_q[2]   <= GRAV_Z_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_MODE:      mode_q      <= pwdata[0];
				REG_TIME_STEP: time_step_q <= pwdata[DT_W-1:0];
				REG_GRAVITY_X: grav_q[0]   <= pwdata;
				REG_GRAVITY_Y: grav_q[1]   <= pwdata;
				REG_GRAVITY_Z: grav_q[2]   <= pwdata;
				default: ;
			endcase
		end
	end

	// read-back
	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_MODE:      prdata = {31'd0, mode_q};
			REG_TIME_STEP: prdata = {1'b0, time_step_q};
			REG_GRAVITY_X: prdata = grav_q[0];
			REG_GRAVITY_Y: prdata = grav_q[1];
			REG_GRAVITY_Z: prdata = grav_q[2];
			default:       prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// clearing pass after reset
	logic          clear_q;
	logic [SW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == SW'(MAX_PARTICLES - 1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// flow control: hold everything only when the last stage has nowhere to go
	logic adv;
	logic in_acc;
	logic vld_s4;
	logic out_valid_q;

	assign adv      = !out_valid_q || !out_stall || !vld_s4;
	assign in_stall = clear_q || !adv;
	assign in_acc   = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// stage 0: request register, force magnitudes and slot quotient
	logic [ND:0]             dvld_s;
	logic [IDX_W-1:0]        didx_s  [ND+1];
	vec3_t                   dpos_s  [ND+1];
	vec3_t                   dvel_s  [ND+1];
	div_flags_t              dflg_s  [ND+1];
	logic [MASS_W-1:0]       dmass_s [ND+1];
	logic [2:0][MASS_W-1:0]  drem_s  [ND+1];
	logic [2:0][DW-1:0]      ddq_s   [ND+1];
	logic [SW-1:0]           dslot_s [1:ND];
	logic [IDX_W-1:0]        mq_s0;

	vec3_t                   in_force;
	logic [2:0][DW-1:0]      in_dvd;
	div_flags_t              in_flg;
	logic [MP_W-1:0]         in_mp;

	always_comb begin
		logic [DATA_W-1:0] mag;
		mag       = '0;
		in_force  = {force_z, force_y, force_x};
		in_flg    = '0;
		in_dvd    = '0;
		for (int l = 0; l < 3; l++) begin
			in_flg.neg[l] = in_force[l][DATA_W-1];
			in_flg.nz[l]  = |in_force[l];
			mag           = in_force[l][DATA_W-1] ? (~in_force[l] + 1'b1) : in_force[l];
			in_dvd[l]     = {mag, {FRAC_BITS{1'b0}}};
		end
		in_flg.mzero = (mass == '0);
		in_mp        = MP_W'(particle_index) * MP_W'(MOD_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_s[0] <= 1'b0;
		end else if (adv) begin
			dvld_s[0] <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			didx_s[0]  <= particle_index;
			dpos_s[0]  <= {pos_z, pos_y, pos_x};
			dvel_s[0]  <= {vel_z, vel_y, vel_x};
			dflg_s[0]  <= in_flg;
			dmass_s[0] <= mass;
			drem_s[0]  <= '0;
			ddq_s[0]   <= in_dvd;
			mq_s0      <= in_mp[MOD_SH +: IDX_W];
		end
	end

	// ------------------------------------------------------------------
	// restoring divider, one quotient bit per stage, three lanes
	for (genvar k = 1; k <= ND; k++) begin : g_div
		logic [2:0][MASS_W-1:0] rem_n;
		logic [2:0][DW-1:0]     dq_n;
		logic [SW-1:0]          slot_n;

		always_comb begin
			logic [MASS_W:0] trial;
			logic            ge;
			trial = '0;
			ge    = 1'b0;
			rem_n = '0;
			dq_n  = '0;
			for (int l = 0; l < 3; l++) begin
				trial    = {drem_s[k-1][l], ddq_s[k-1][l][DW-1]};
				ge       = (trial >= {1'b0, dmass_s[k-1]});
				rem_n[l] = ge ? MASS_W'(trial - {1'b0, dmass_s[k-1]}) : trial[MASS_W-1:0];
				dq_n[l]  = {ddq_s[k-1][l][DW-2:0], ge};
			end
		end

		if (k == 1) begin : g_slot
			// remainder of the index, one correction step
			always_comb begin
				logic [2*IDX_W+1:0] pr;
				logic [IDX_W:0]     r;
				pr = (2*IDX_W+2)'(mq_s0) * (2*IDX_W+2)'(MOD_M);
				r  = {1'b0, didx_s[0]} - pr[IDX_W:0];
				if (r >= MOD_M) begin
					r = r - MOD_M;
				end
				if (FULL_IDX) begin
					slot_n = SW'(didx_s[0]);
				end else begin
					slot_n = SW'(r);
				end
			end
		end else begin : g_slot_pass
			assign slot_n = dslot_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[k] <= 1'b0;
			end else if (adv) begin
				dvld_s[k] <= dvld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				didx_s[k]  <= didx_s[k-1];
				dpos_s[k]  <= dpos_s[k-1];
				dvel_s[k]  <= dvel_s[k-1];
				dflg_s[k]  <= dflg_s[k-1];
				dmass_s[k] <= dmass_s[k-1];
				drem_s[k]  <= rem_n;
				ddq_s[k]   <= dq_n;
				dslot_s[k] <= slot_n;
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 1: signed quotient plus gravity; previous acceleration read
	logic                 avld_s1;
	logic [SW-1:0]        aslot_s1;
	logic [IDX_W-1:0]     aidx_s1;
	vec3_t                apos_s1;
	vec3_t                avel_s1;
	vec3_t                aacc_s1;
	logic                 fwd_s1;
	vec3_t                fwdacc_s1;
	vec3_t                acc_n;

	always_comb begin
		logic signed [DW:0]  qs;
		logic signed [63:0]  sum;
		qs    = '0;
		sum   = '0;
		acc_n = '0;
		for (int l = 0; l < 3; l++) begin
			qs = dflg_s[ND].neg[l] ? -$signed({1'b0, ddq_s[ND][l]}) : $signed({1'b0, ddq_s[ND][l]});
			// zero mass: full-scale quotient in the force's direction
			if (dflg_s[ND].mzero) begin
				if (!dflg_s[ND].nz[l]) begin
					qs = '0;
				end else if (dflg_s[ND].neg[l]) begin
					qs = -(DW+1)'(33'sh0_8000_0000);
				end else begin
					qs = (DW+1)'(33'sh0_7FFF_FFFF);
				end
			end
			sum      = sx64(grav_q[l]) + {{(63-DW){qs[DW]}}, qs};
			acc_n[l] = sat32(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avld_s1 <= 1'b0;
		end else if (adv) begin
			avld_s1 <= dvld_s[ND];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			aslot_s1  <= dslot_s[ND];
			aidx_s1   <= didx_s[ND];
			apos_s1   <= dpos_s[ND];
			avel_s1   <= dvel_s[ND];
			aacc_s1   <= acc_n;
			// the entry written this cycle is not yet visible to the read
			fwd_s1    <= avld_s1 && (aslot_s1 == dslot_s[ND]);
			fwdacc_s1 <= aacc_s1;
		end
	end

	// acceleration store
	logic             ram_we;
	logic [SW-1:0]    ram_waddr;
	logic [MEM_W-1:0] ram_wdata;
	logic [MEM_W-1:0] ram_rdata;

	assign ram_we    = clear_q || (avld_s1 && adv);
	assign ram_waddr = clear_q ? clr_addr_q : aslot_s1;
	assign ram_wdata = clear_q ? '0 : aacc_s1;

	pmi_ram #(
		.WIDTH(MEM_W),
		.DEPTH(MAX_PARTICLES),
		.AW   (SW)
	) u_acc_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (adv),
		.raddr(dslot_s[ND]),
		.rdata(ram_rdata)
	);

	// ------------------------------------------------------------------
	// stage 2: time step times acceleration (or trapezoid sum)
	logic                   vld_s2;
	logic [IDX_W-1:0]       idx_s2;
	vec3_t                  pos_s2;
	vec3_t                  vel_s2;
	vec3_t                  acc_s2;
	logic [2:0][63:0]       prod_s2;
	logic [2:0][63:0]       prod_n2;
	vec3_t                  a_old;
	logic signed [DATA_W-1:0] dts;

	assign dts   = $signed({1'b0, time_step_q});
	assign a_old = fwd_s1 ? fwdacc_s1 : ram_rdata;

	always_comb begin
		logic signed [DATA_W:0] op;
		logic signed [64:0]     full;
		op      = '0;
		full    = '0;
		prod_n2 = '0;
		for (int l = 0; l < 3; l++) begin
			op         = mode_q ? (sx33(a_old[l]) + sx33(aacc_s1[l])) : sx33(aacc_s1[l]);
			full       = dts * op;
			prod_n2[l] = full[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= avld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s2  <= aidx_s1;
			pos_s2  <= apos_s1;
			vel_s2  <= avel_s1;
			acc_s2  <= aacc_s1;
			prod_s2 <= prod_n2;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: new velocity
	logic             vld_s3;
	logic [IDX_W-1:0] idx_s3;
	vec3_t            pos_s3;
	vec3_t            vel_s3;
	vec3_t            acc_s3;
	vec3_t            nv_s3;
	vec3_t            nv_n;

	always_comb begin
		logic signed [63:0] sh;
		sh   = '0;
		nv_n = '0;
		for (int l = 0; l < 3; l++) begin
			sh      = mode_q ? ($signed(prod_s2[l]) >>> (FRAC_BITS + 1))
			                 : ($signed(prod_s2[l]) >>> FRAC_BITS);
			nv_n[l] = sat32(sx64(vel_s2[l]) + sh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s3 <= idx_s2;
			pos_s3 <= pos_s2;
			vel_s3 <= vel_s2;
			acc_s3 <= acc_s2;
			nv_s3  <= nv_n;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: time step times new velocity (or velocity sum)
	logic             [IDX_W-1:0] idx_s4;
	vec3_t            pos_s4;
	vec3_t            nv_s4;
	vec3_t            acc_s4;
	logic [2:0][63:0] prod_s4;
	logic [2:0][63:0] prod_n4;

	always_comb begin
		logic signed [DATA_W:0] op;
		logic signed [64:0]     full;
		op      = '0;
		full    = '0;
		prod_n4 = '0;
		for (int l = 0; l < 3; l++) begin
			op         = mode_q ? (sx33(vel_s3[l]) + sx33(nv_s3[l])) : sx33(nv_s3[l]);
			full       = dts * op;
			prod_n4[l] = full[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s4  <= idx_s3;
			pos_s4  <= pos_s3;
			nv_s4   <= nv_s3;
			acc_s4  <= acc_s3;
			prod_s4 <= prod_n4;
		end
	end

	// ------------------------------------------------------------------
	// output register: new position
	logic [IDX_W-1:0] out_idx_q;
	vec3_t            out_pos_q;
	vec3_t            out_vel_q;
	vec3_t            out_acc_q;
	vec3_t            np_n;
	logic             out_load;

	assign out_load = !out_valid_q || !out_stall;

	always_comb begin
		logic signed [63:0] sh;
		sh   = '0;
		np_n = '0;
		for (int l = 0; l < 3; l++) begin
			sh      = mode_q ? ($signed(prod_s4[l]) >>> (FRAC_BITS + 1))
			                 : ($signed(prod_s4[l]) >>> FRAC_BITS);
			np_n[l] = sat32(sx64(pos_s4[l]) + sh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q <= idx_s4;
			out_pos_q <= np_n;
			out_vel_q <= nv_s4;
			out_acc_q <= acc_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_idx_q;
	assign new_pos_x = out_pos_q[0];
	assign new_pos_y = out_pos_q[1];
	assign new_pos_z = out_pos_q[2];
	assign new_vel_x = out_vel_q[0];
	assign new_vel_y = out_vel_q[1];
	assign new_vel_z = out_vel_q[2];
	assign new_acc_x = out_acc_q[0];
	assign new_acc_y = out_acc_q[1];
	assign new_acc_z = out_acc_q[2];

	// ------------------------------------------------------------------
	// checks
	`PMI_ASSERT_NOW(a_clear_empty, clear_q, !(|dvld_s) && !avld_s1 && !vld_s2 && !vld_s3 && !vld_s4, "pipeline occupied during RAM clear")
	`PMI_ASSERT_NOW(a_out_source, $rose(out_valid_q), $past(vld_s4), "result appeared without a source stage")
	`PMI_ASSERT_NEXT(a_hold, !adv, $stable({dvld_s, avld_s1, vld_s2, vld_s3, vld_s4}), "pipeline moved while held")

endmodule

/* rtl/pmi_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module pmi_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the particle motion integrator core: random and directed particles,
// APB configuration phases, scoreboard with its own Q16.16 integrator model.
// Depends on pmi_pkg and particle_motion_integrator_core.
`timescale 1ns / 1ps

module tb_top;
	import pmi_pkg::*;

	typedef struct {
		logic [9:0]         idx;
		logic signed [31:0] p [3];
		logic signed [31:0] v [3];
		logic signed [31:0] f [3];
		logic [30:0]        m;
	} particle_t;

	typedef struct {
		logic [9:0]         idx;
		logic signed [31:0] np [3];
		logic signed [31:0] nv [3];
		logic signed [31:0] na [3];
	} motion_t;

	int unsigned n_mismatch = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		n_mismatch++;
	endtask

	// integrator model and queue of pending updates
	class motion_scoreboard;
		bit                 trap_mode;
		longint             dt;
		longint             grav [3];
		logic signed [31:0] acc_store [3][1024];
		motion_t            pending [$];

		function new();
			trap_mode = 0;
			dt = 65;
			grav[0] = 0; grav[1] = 0; grav[2] = -642253;
			foreach (acc_store[k, i]) acc_store[k][i] = '0;
		endfunction

		function longint clamp(input longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		// arithmetic shift floors, as required
		function longint floor_shift(input longint x, input int n);
			return x >>> n;
		endfunction

		function void note_particle(input particle_t it);
			motion_t r;
			longint p, v, f, a_old, q, a, nv, np;
			r.idx = it.idx;
			for (int k = 0; k < 3; k++) begin
				p = it.p[k]; v = it.v[k]; f = it.f[k];
				a_old = acc_store[k][it.idx];
				if (it.m == 0) q = f > 0 ? 64'sd2147483647 : (f < 0 ? -64'sd2147483648 : 0);
				else q = (f * 65536) / longint'(it.m);
				a = clamp(grav[k] + q);
				if (!trap_mode) begin
					nv = clamp(v + floor_shift(dt * a, 16));
					np = clamp(p + floor_shift(dt * nv, 16));
				end else begin
					nv = clamp(v + floor_shift(dt * (a_old + a), 17));
					np = clamp(p + floor_shift(dt * (v + nv), 17));
				end
				acc_store[k][it.idx] = a[31:0];
				r.np[k] = np[31:0]; r.nv[k] = nv[31:0]; r.na[k] = a[31:0];
			end
			pending.push_back(r);
		endfunction

		task check_result(input motion_t got);
			motion_t w;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result idx", got.idx, 0);
				return;
			end
			w = pending.pop_front();
			if (got.idx !== w.idx) report_mismatch("out_index", got.idx, w.idx);
			for (int k = 0; k < 3; k++) begin
				if (got.np[k] !== w.np[k]) report_mismatch($sformatf("new_pos[%0d]", k), got.np[k], w.np[k]);
				if (got.nv[k] !== w.nv[k]) report_mismatch($sformatf("new_vel[%0d]", k), got.nv[k], w.nv[k]);
				if (got.na[k] !== w.na[k]) report_mismatch($sformatf("new_acc[%0d]", k), got.na[k], w.na[k]);
			end
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	logic in_valid = 0, in_stall;
	logic [9:0] particle_index = '0;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0, vel_x = 0, vel_y = 0, vel_z = 0;
	logic signed [31:0] force_x = 0, force_y = 0, force_z = 0;
	logic [30:0] mass = 31'd65536;
	logic out_valid, out_stall = 0;
	logic [9:0] out_index;
	logic signed [31:0] new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z;
	logic signed [31:0] new_acc_x, new_acc_y, new_acc_z;

	particle_motion_integrator_core u_top (.*);

	motion_scoreboard sb = new();
	int send_gap_pct = 7, recv_gap_pct = 54;
	int hold_off_cycles = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: random stall, plus long hold-off on request
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			out_stall <= 1;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_gap_pct);
		end
	end

	// sample results
	always @(posedge clk) begin
		motion_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.idx = out_index;
			got.np[0] = new_pos_x; got.np[1] = new_pos_y; got.np[2] = new_pos_z;
			got.nv[0] = new_vel_x; got.nv[1] = new_vel_y; got.nv[2] = new_vel_z;
			got.na[0] = new_acc_x; got.na[1] = new_acc_y; got.na[2] = new_acc_z;
			sb.check_result(got);
		end
	end

	task automatic apb_write(input reg_idx_t r, input logic [31:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= ADDR_W'(r) << 2; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (r)
			REG_MODE:      sb.trap_mode = val[0];
			REG_TIME_STEP: sb.dt = val[30:0];
			REG_GRAVITY_X: sb.grav[0] = longint'(signed'(val));
			REG_GRAVITY_Y: sb.grav[1] = longint'(signed'(val));
			REG_GRAVITY_Z: sb.grav[2] = longint'(signed'(val));
			default: ;
		endcase
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// entered at a falling edge; leaves at the falling edge after acceptance with
	// in_valid still high so the next request can follow directly
	task automatic send_particle(input particle_t it);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1; particle_index <= it.idx; mass <= it.m;
		pos_x <= it.p[0]; pos_y <= it.p[1]; pos_z <= it.p[2];
		vel_x <= it.v[0]; vel_y <= it.v[1]; vel_z <= it.v[2];
		force_x <= it.f[0]; force_y <= it.f[1]; force_z <= it.f[2];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_particle(it);
		@(negedge clk);
	endtask

	task automatic drain();
		int n = 0;
		in_valid <= 0;
		while (sb.pending.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (70) @(posedge clk);
	endtask

	// random content; extremes mixed in, small indices for store reuse
	function automatic logic [31:0] rand_q();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(262143) - 131072;
			default: return $urandom;
		endcase
	endfunction

	function automatic particle_t rand_particle();
		particle_t it;
		it.idx = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(15));
		for (int k = 0; k < 3; k++) begin
			it.p[k] = rand_q(); it.v[k] = rand_q(); it.f[k] = rand_q();
		end
		case ($urandom_range(4))
			0: it.m = 31'h7FFF_FFFF;
			1: it.m = 31'($urandom_range(4));
			default: it.m = 31'($urandom);
		endcase
		return it;
	endfunction

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) send_particle(rand_particle());
	endtask

	initial begin
		particle_t it;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1;

		// directed: extremes, zero mass with each force sign, index reuse
		for (int d = 0; d < 12; d++) begin
			it.idx = (d < 10) ? 10'(d % 3) : 10'h3FF;
			for (int k = 0; k < 3; k++) begin
				it.p[k] = (d & 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				it.v[k] = (d & 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
				it.f[k] = (k == 0) ? 32'h7FFF_FFFF : (k == 1 ? 32'h8000_0000 : 32'h0);
			end
			it.m = (d < 4) ? 31'd0 : ((d & 4) ? 31'h7FFF_FFFF : 31'd1);
			send_particle(it);
		end
		drain();
		apb_write(REG_MODE, 32'd1);
		apb_write(REG_TIME_STEP, 32'h7FFF_FFFF);
		apb_write(REG_GRAVITY_X, 32'h7FFF_FFFF);
		apb_write(REG_GRAVITY_Y, 32'h8000_0000);
		apb_write(REG_GRAVITY_Z, 32'd0);
		for (int d = 0; d < 10; d++) begin
			it = rand_particle();
			it.idx = 10'(d % 2);
			send_particle(it);
		end
		drain();

		// random, sender rarely idle, receiver often
		apb_write(REG_TIME_STEP, 32'd65536);
		apb_write(REG_GRAVITY_X, 32'd0);
		apb_write(REG_GRAVITY_Y, 32'd0);
		apb_write(REG_GRAVITY_Z, 32'hFFF6_3333);
		random_phase(200);
		drain();

		// swapped idling, Euler, zero step
		send_gap_pct = 54; recv_gap_pct = 7;
		apb_write(REG_MODE, 32'd0);
		apb_write(REG_TIME_STEP, 32'd0);
		random_phase(60);
		drain();
		apb_write(REG_TIME_STEP, $urandom);
		apb_write(REG_GRAVITY_X, $urandom);
		random_phase(150);
		drain();

		// no idling; long receiver hold-off so the pipeline backs up
		send_gap_pct = 0; recv_gap_pct = 0;
		apb_write(REG_MODE, 32'd1);
		apb_write(REG_TIME_STEP, 32'd655);
		@(negedge clk) hold_off_cycles <= 300;
		random_phase(220);
		drain();

		// anything still expected never arrived
		if (sb.pending.size() != 0) begin
			report_mismatch("results outstanding", sb.pending.size(), 0);
		end

		if (n_mismatch == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
